@@ rtl/pid_controller_filtered_derivative_unit_macros.svh @@
// Assertion macros for the PID controller unit checker.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_UNIT_MACROS_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PCFD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication, checked out of reset
`define PCFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

@@ rtl/pcfd_pkg.sv @@
// Shared types, register map and saturating arithmetic for the PID controller unit.
// No dependencies.
`default_nettype none

package pcfd_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;
	// widest gain product: 32-bit gain times 18-bit error sum
	localparam int PROD_W = 50;

	// register indexes (byte address / 4)
	localparam logic [IDX_W-1:0] REG_KP        = 3'd0;
	localparam logic [IDX_W-1:0] REG_KI_HALF_T = 3'd1;
	localparam logic [IDX_W-1:0] REG_KD_SCALED = 3'd2;
	localparam logic [IDX_W-1:0] REG_D_POLE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_OUT_MIN   = 3'd4;
	localparam logic [IDX_W-1:0] REG_OUT_MAX   = 3'd5;
	localparam logic [IDX_W-1:0] REG_INT_MIN   = 3'd6;
	localparam logic [IDX_W-1:0] REG_INT_MAX   = 3'd7;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
	localparam logic signed [15:0] S16_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [31:0] kp;
		logic signed [31:0] ki_half_t;
		logic signed [31:0] kd_scaled;
		logic signed [16:0] d_pole;
		logic signed [15:0] out_min;
		logic signed [15:0] out_max;
		logic signed [15:0] int_min;
		logic signed [15:0] int_max;
	} cfg_t;

	// saturate a gain product to signed 32 bits
	function automatic logic signed [31:0] sat_prod(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-32:0] top;
		top = v[PROD_W-1:31];
		if ((&top) || !(|top)) begin
			return v[31:0];
		end else if (v[PROD_W-1]) begin
			return S32_MIN;
		end else begin
			return S32_MAX;
		end
	endfunction

	// saturating signed 32-bit add
	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] == s[31]) begin
			return s[31:0];
		end else if (s[32]) begin
			return S32_MIN;
		end else begin
			return S32_MAX;
		end
	endfunction

	// saturating signed 32-bit negate
	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
		if (a == S32_MIN) begin
			return S32_MAX;
		end else begin
			return -a;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/pid_controller_filtered_derivative_unit.sv @@
// PID controller: trapezoidal integrator with clamp, filtered derivative on measurement.
// Throughput: one word per cycle unless stalled; four pipeline registers (s1, s2, s3,
// output) each stall only when full and blocked, so the input keeps flowing while a
// result waits, until every stage ahead of the input is full.
// The integrator and derivative filter update when a word leaves s2 (multiply-add loop).
// Reset (arst_n low, async): pipeline empty, filter state zero, registers at defaults.
`default_nettype none

module pid_controller_filtered_derivative_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pcfd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pcfd_pkg::DATA_W-1:0]  pwdata,
	output logic      [pcfd_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	// input channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [15:0]           target,
	input  wire logic signed [15:0]           sample,
	// output channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [15:0]                drive,
	output logic                              limited
);

	pcfd_pkg::cfg_t cfg;

	pcfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// stage valids and flow control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// stage 1: error, error sum and measurement step
	logic signed [15:0] last_smp_q;
	logic signed [16:0] last_err_q;
	logic signed [16:0] err;
	logic signed [17:0] esum;
	logic signed [16:0] dsmp;
	logic signed [16:0] err_s1;
	logic signed [17:0] esum_s1;
	logic signed [16:0] dsmp_s1;

	assign err  = 17'(target) - 17'(sample);
	assign esum = 18'(err) + 18'(last_err_q);
	assign dsmp = 17'(sample) - 17'(last_smp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			last_smp_q <= '0;
		end else if (in_valid && rdy_s1) begin
			last_err_q <= err;
			last_smp_q <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			err_s1  <= err;
			esum_s1 <= esum;
			dsmp_s1 <= dsmp;
		end
	end

	// stage 2: gain products, saturated
	logic signed [pcfd_pkg::PROD_W-1:0] p_kp, p_ki, p_kd;
	logic signed [31:0] prop_s2, iinc_s2, kdp_s2;

	assign p_kp = $signed(cfg.kp) * $signed(err_s1);
	assign p_ki = $signed(cfg.ki_half_t) * $signed(esum_s1);
	assign p_kd = $signed(cfg.kd_scaled) * $signed(dsmp_s1);

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			prop_s2 <= pcfd_pkg::sat_prod(p_kp);
			iinc_s2 <= pcfd_pkg::sat_prod(p_ki);
			kdp_s2  <= pcfd_pkg::sat_prod(p_kd);
		end
	end

	// stage 3: integrator and derivative filter state update
	logic signed [31:0] integ_q, deriv_q;
	logic signed [31:0] isum, ihi, ilo, integ_nxt;
	logic signed [48:0] dprod;
	logic signed [31:0] dfb, dterm, deriv_nxt;
	logic signed [31:0] prop_s3;

	assign isum = pcfd_pkg::add_sat(integ_q, iinc_s2);
	assign ihi  = {cfg.int_max, 16'h0000};
	assign ilo  = {cfg.int_min, 16'h0000};

	// upper clamp is checked first; with inverted limits a sum above the upper limit takes it, any other the lower
	always_comb begin
		if (isum > ihi) begin
			integ_nxt = ihi;
		end else if (isum < ilo) begin
			integ_nxt = ilo;
		end else begin
			integ_nxt = isum;
		end
	end

	// pole feedback: floor shift by 16, saturate the 33-bit result
	assign dprod = $signed(cfg.d_pole) * $signed(deriv_q);

	always_comb begin
		if (dprod[48] == dprod[47]) begin
			dfb = dprod[47:16];
		end else if (dprod[48]) begin
			dfb = pcfd_pkg::S32_MIN;
		end else begin
			dfb = pcfd_pkg::S32_MAX;
		end
	end

	assign dterm     = pcfd_pkg::add_sat(kdp_s2, dfb);
	assign deriv_nxt = pcfd_pkg::neg_sat(dterm);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			deriv_q <= '0;
		end else if (v_s2 && rdy_s3) begin
			integ_q <= integ_nxt;
			deriv_q <= deriv_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			prop_s3 <= prop_s2;
		end
	end

	// output: sum terms, floor to integer, clamp
	logic signed [31:0] sum;
	logic signed [15:0] y, drive_d;
	logic               lim_d;
	logic signed [15:0] drive_q;
	logic               limited_q;

	assign sum = pcfd_pkg::add_sat(pcfd_pkg::add_sat(prop_s3, integ_q), deriv_q);
	assign y   = sum[31:16];

	always_comb begin
		if (y > cfg.out_max) begin
			drive_d = cfg.out_max;
			lim_d   = 1'b1;
		end else if (y < cfg.out_min) begin
			drive_d = cfg.out_min;
			lim_d   = 1'b1;
		end else begin
			drive_d = y;
			lim_d   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_out) begin
			drive_q   <= drive_d;
			limited_q <= lim_d;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign limited   = limited_q;

endmodule

`default_nettype wire

@@ rtl/pcfd_regs.sv @@
// APB-style configuration register file for the PID controller unit.
// Depends on pcfd_pkg.
`default_nettype none

module pcfd_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pcfd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pcfd_pkg::DATA_W-1:0]  pwdata,
	output logic      [pcfd_pkg::DATA_W-1:0]  prdata,
	output pcfd_pkg::cfg_t                    cfg
);

	logic                          wr_en;
	logic [pcfd_pkg::IDX_W-1:0]    idx;
	pcfd_pkg::cfg_t                cfg_q;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[pcfd_pkg::ADDR_W-1:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp        <= '0;
			cfg_q.ki_half_t <= '0;
			cfg_q.kd_scaled <= '0;
			cfg_q.d_pole    <= '0;
			cfg_q.out_min   <= pcfd_pkg::S16_MIN;
			cfg_q.out_max   <= pcfd_pkg::S16_MAX;
			cfg_q.int_min   <= pcfd_pkg::S16_MIN;
			cfg_q.int_max   <= pcfd_pkg::S16_MAX;
		end else if (wr_en) begin
			case (idx)
				pcfd_pkg::REG_KP:        cfg_q.kp        <= pwdata;
				pcfd_pkg::REG_KI_HALF_T: cfg_q.ki_half_t <= pwdata;
				pcfd_pkg::REG_KD_SCALED: cfg_q.kd_scaled <= pwdata;
				pcfd_pkg::REG_D_POLE:    cfg_q.d_pole    <= pwdata[16:0];
				pcfd_pkg::REG_OUT_MIN:   cfg_q.out_min   <= pwdata[15:0];
				pcfd_pkg::REG_OUT_MAX:   cfg_q.out_max   <= pwdata[15:0];
				pcfd_pkg::REG_INT_MIN:   cfg_q.int_min   <= pwdata[15:0];
				pcfd_pkg::REG_INT_MAX:   cfg_q.int_max   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux, narrow registers sign-extended
	always_comb begin
		case (idx)
			pcfd_pkg::REG_KP:        prdata = cfg_q.kp;
			pcfd_pkg::REG_KI_HALF_T: prdata = cfg_q.ki_half_t;
			pcfd_pkg::REG_KD_SCALED: prdata = cfg_q.kd_scaled;
			pcfd_pkg::REG_D_POLE:    prdata = {{15{cfg_q.d_pole[16]}}, cfg_q.d_pole};
			pcfd_pkg::REG_OUT_MIN:   prdata = {{16{cfg_q.out_min[15]}}, cfg_q.out_min};
			pcfd_pkg::REG_OUT_MAX:   prdata = {{16{cfg_q.out_max[15]}}, cfg_q.out_max};
			pcfd_pkg::REG_INT_MIN:   prdata = {{16{cfg_q.int_min[15]}}, cfg_q.int_min};
			pcfd_pkg::REG_INT_MAX:   prdata = {{16{cfg_q.int_max[15]}}, cfg_q.int_max};
			default:                 prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/pcfd_checker.sv @@
// Port-level checker for the PID controller unit, bound to the top level.
// Depends on pid_controller_filtered_derivative_unit_macros.svh.
`default_nettype none

`include "pid_controller_filtered_derivative_unit_macros.svh"

module pcfd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic signed [15:0] drive,
	input wire logic              limited
);

	// a stalled result word holds
	`PCFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive) && $stable(limited))

	// a result appearing on an empty output came from a word accepted at the input
	`PCFD_ASSERT_NOW(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 4))

	// the input blocks only when the output is full and back-pressured
	`PCFD_ASSERT_NOW(a_in_block, !in_ready, out_valid && !out_ready)

endmodule

bind pid_controller_filtered_derivative_unit pcfd_checker u_pcfd_checker (.*);

`default_nettype wire
